// ===== rtl/core/chs_pkg.sv =====
package chs_pkg;

    // Fraction bits of the two uniform inputs and the field widths.
    localparam int FRAC_BITS    = 16;
    localparam int IN_W         = 16;
    localparam int UWIDE_W      = IN_W + 32 - FRAC_BITS;
    // Root bits (Q30 results up to and including 1.0) and the radicand width.
    localparam int SQ_W         = 31;
    localparam int RAD_W        = 2 * SQ_W - 1;
    localparam int CORDIC_STEPS = 24;
    localparam int XW           = 33;
    localparam int ZW           = 34;
    localparam int GAIN_W       = 30;
    localparam int PROD_W       = SQ_W + GAIN_W;
    localparam logic [GAIN_W-1:0] CORDIC_GAIN = GAIN_W'(652032874);
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // One partial square root: remainder and the root bits found so far.
    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [SQ_W-1:0]  root;
    } chs_sq_t;

    // Phase and start-vector sign that travel beside the square roots.
    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } chs_side_t;

    // CORDIC rotation vector with its residual phase.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } chs_cv_t;

    // Arctangent of 2^-i in Q32 turns.
    function automatic logic signed [ZW-1:0] atan_q32(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = ZW'(536870912);
            1:       a = ZW'(316933406);
            2:       a = ZW'(167458907);
            3:       a = ZW'(84999124);
            4:       a = ZW'(42667331);
            5:       a = ZW'(21354465);
            6:       a = ZW'(10679838);
            7:       a = ZW'(5340245);
            8:       a = ZW'(2670163);
            9:       a = ZW'(1335087);
            10:      a = ZW'(667544);
            11:      a = ZW'(333772);
            12:      a = ZW'(166886);
            13:      a = ZW'(83443);
            14:      a = ZW'(41722);
            15:      a = ZW'(20861);
            16:      a = ZW'(10430);
            17:      a = ZW'(5215);
            18:      a = ZW'(2608);
            19:      a = ZW'(1304);
            20:      a = ZW'(652);
            21:      a = ZW'(326);
            22:      a = ZW'(163);
            23:      a = ZW'(81);
            default: a = '0;
        endcase
        return a;
    endfunction

    // One digit of a restoring square root, deciding root bit b.
    function automatic chs_sq_t sqrt_step(input chs_sq_t a, input int b);
        chs_sq_t          r;
        logic [RAD_W:0]   t;
        t = ((RAD_W + 1)'(a.root) << (b + 1)) + ((RAD_W + 1)'(1) << (2 * b));
        r = a;
        if ({1'b0, a.rem} >= t)
        begin
            r.rem  = a.rem - t[RAD_W-1:0];
            r.root = a.root | (SQ_W'(1) << b);
        end
        return r;
    endfunction

    // One CORDIC rotation with flooring shifts.
    function automatic chs_cv_t cordic_step(input chs_cv_t v, input int i);
        chs_cv_t              r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.z >= 0)
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - atan_q32(i);
        end
        else
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + atan_q32(i);
        end
        return r;
    endfunction

    // Q30 to Q15 with round to nearest and saturation.
    function automatic logic signed [15:0] q30_to_q15(input logic signed [XW-1:0] v,
                                                      input logic signed [XW-1:0] lo,
                                                      input logic signed [XW-1:0] hi);
        logic signed [XW-1:0] t;
        t = (v + XW'(16384)) >>> 15;
        if (t < lo)
            t = lo;
        if (t > hi)
            t = hi;
        return t[15:0];
    endfunction

endpackage

// ===== rtl/core/cosine_hemisphere_sampler_top.sv =====
// Cosine-weighted hemisphere sampler: takes one request of two uniform Q0.16 numbers per
// cycle while not stalled and returns a Q1.15 unit direction around +y, one result per
// request in order. The path runs through the 31-stage bit-per-stage square root, one
// gain-multiply stage, the 24-stage CORDIC rotator and the output register; a stall on
// the result side freezes the whole pipeline and holds the input side stalled with it.
module cosine_hemisphere_sampler_top
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [chs_pkg::IN_W-1:0] u_radius,
    input  logic [chs_pkg::IN_W-1:0] u_angle,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [15:0]       dir_x,
    output logic [14:0]              dir_y,
    output logic signed [15:0]       dir_z
);

    logic                         en;
    logic [chs_pkg::UWIDE_W-1:0]  u_wide;
    logic [32:0]                  u_cl;
    logic [chs_pkg::RAD_W-1:0]    rad_r;
    logic [chs_pkg::RAD_W-1:0]    rad_y;
    logic [31:0]                  ph;
    logic [31:0]                  ph_adj;
    chs_pkg::chs_side_t           side_in;

    logic                         sq_vld;
    logic [chs_pkg::SQ_W-1:0]     root_r;
    logic [chs_pkg::SQ_W-1:0]     root_y;
    chs_pkg::chs_side_t           sq_side;

    logic                         mul_valid_reg;
    logic [chs_pkg::PROD_W-1:0]   prod_reg;
    logic [chs_pkg::SQ_W-1:0]     ny_reg;
    chs_pkg::chs_side_t           mside_reg;
    logic signed [chs_pkg::XW-1:0] x_mag;
    chs_pkg::chs_cv_t             vec0;

    logic                         cd_vld;
    chs_pkg::chs_cv_t             vec_out;
    logic [chs_pkg::SQ_W-1:0]     ny_out;

    logic                         out_valid_reg;
    logic signed [15:0]           dir_x_reg;
    logic [14:0]                  dir_y_reg;
    logic signed [15:0]           dir_z_reg;
    logic signed [15:0]           y_round;

    // The pipeline moves unless a finished result is being held back.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Radicands for sqrt(u) and sqrt(1 - u), with u clamped to one.
    always_comb
    begin
        u_wide = chs_pkg::UWIDE_W'(u_radius) << (32 - chs_pkg::FRAC_BITS);
        if ((chs_pkg::UWIDE_W + 33)'(u_wide) > (chs_pkg::UWIDE_W + 33)'(chs_pkg::ONE_Q32))
            u_cl = chs_pkg::ONE_Q32;
        else
            u_cl = 33'(u_wide);
        rad_r = chs_pkg::RAD_W'(u_cl) << 28;
        rad_y = chs_pkg::RAD_W'(chs_pkg::ONE_Q32 - u_cl) << 28;
    end

    // Fold the second and third quarter turns onto the first and fourth.
    always_comb
    begin
        ph          = 32'(chs_pkg::UWIDE_W'(u_angle) << (32 - chs_pkg::FRAC_BITS));
        side_in.neg = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
        ph_adj      = side_in.neg ? (ph + 32'h8000_0000) : ph;
        side_in.z   = chs_pkg::ZW'($signed(ph_adj));
    end

    chs_sqrt_pipe u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .rad_r    (rad_r),
        .rad_y    (rad_y),
        .side_in  (side_in),
        .out_vld  (sq_vld),
        .root_r   (root_r),
        .root_y   (root_y),
        .side_out (sq_side)
    );

    // Gain compensation multiply, registered before the rotator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (en)
            mul_valid_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= chs_pkg::PROD_W'(root_r) * chs_pkg::PROD_W'(chs_pkg::CORDIC_GAIN);
            ny_reg    <= root_y;
            mside_reg <= sq_side;
        end
    end

    // Start vector on the x axis, negated for a folded phase.
    always_comb
    begin
        x_mag  = chs_pkg::XW'(prod_reg >> 30);
        vec0.x = mside_reg.neg ? -x_mag : x_mag;
        vec0.y = '0;
        vec0.z = mside_reg.z;
    end

    chs_cordic_pipe u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (mul_valid_reg),
        .vec_in  (vec0),
        .ny_in   (ny_reg),
        .out_vld (cd_vld),
        .vec_out (vec_out),
        .ny_out  (ny_out)
    );

    // Rounding and saturation into the output register.
    assign y_round = chs_pkg::q30_to_q15(chs_pkg::XW'(ny_out), chs_pkg::XW'(0),
                                         chs_pkg::XW'(32767));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cd_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_x_reg <= chs_pkg::q30_to_q15(vec_out.x, -chs_pkg::XW'(32768),
                                             chs_pkg::XW'(32767));
            dir_z_reg <= chs_pkg::q30_to_q15(vec_out.y, -chs_pkg::XW'(32768),
                                             chs_pkg::XW'(32767));
            dir_y_reg <= y_round[14:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign dir_x     = dir_x_reg;
    assign dir_y     = dir_y_reg;
    assign dir_z     = dir_z_reg;

endmodule

// ===== rtl/core/chs_sqrt_pipe.sv =====
module chs_sqrt_pipe
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [chs_pkg::RAD_W-1:0] rad_r,
    input  logic [chs_pkg::RAD_W-1:0] rad_y,
    input  chs_pkg::chs_side_t        side_in,
    output logic                      out_vld,
    output logic [chs_pkg::SQ_W-1:0]  root_r,
    output logic [chs_pkg::SQ_W-1:0]  root_y,
    output chs_pkg::chs_side_t        side_out
);

    logic               valid_reg [chs_pkg::SQ_W];
    chs_pkg::chs_sq_t   sr_reg    [chs_pkg::SQ_W];
    chs_pkg::chs_sq_t   sy_reg    [chs_pkg::SQ_W];
    chs_pkg::chs_side_t side_reg  [chs_pkg::SQ_W];

    // One root bit per stage, most significant first, for both roots.
    for (genvar s = 0; s < chs_pkg::SQ_W; s++)
    begin : g_stage
        logic               v_in;
        chs_pkg::chs_sq_t   r_in;
        chs_pkg::chs_sq_t   y_in;
        chs_pkg::chs_side_t d_in;

        if (s == 0)
        begin : g_first
            assign v_in = in_vld;
            assign r_in = '{rem: rad_r, root: '0};
            assign y_in = '{rem: rad_y, root: '0};
            assign d_in = side_in;
        end
        else
        begin : g_next
            assign v_in = valid_reg[s-1];
            assign r_in = sr_reg[s-1];
            assign y_in = sy_reg[s-1];
            assign d_in = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg[s]   <= chs_pkg::sqrt_step(r_in, chs_pkg::SQ_W - 1 - s);
                sy_reg[s]   <= chs_pkg::sqrt_step(y_in, chs_pkg::SQ_W - 1 - s);
                side_reg[s] <= d_in;
            end
        end
    end

    assign out_vld  = valid_reg[chs_pkg::SQ_W-1];
    assign root_r   = sr_reg[chs_pkg::SQ_W-1].root;
    assign root_y   = sy_reg[chs_pkg::SQ_W-1].root;
    assign side_out = side_reg[chs_pkg::SQ_W-1];

endmodule

// ===== rtl/core/chs_cordic_pipe.sv =====
module chs_cordic_pipe
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  chs_pkg::chs_cv_t         vec_in,
    input  logic [chs_pkg::SQ_W-1:0] ny_in,
    output logic                     out_vld,
    output chs_pkg::chs_cv_t         vec_out,
    output logic [chs_pkg::SQ_W-1:0] ny_out
);

    logic                     valid_reg [chs_pkg::CORDIC_STEPS];
    chs_pkg::chs_cv_t         vec_reg   [chs_pkg::CORDIC_STEPS];
    logic [chs_pkg::SQ_W-1:0] ny_reg    [chs_pkg::CORDIC_STEPS];

    // One rotation per stage; the normal component rides alongside.
    for (genvar s = 0; s < chs_pkg::CORDIC_STEPS; s++)
    begin : g_stage
        logic                     v_in;
        chs_pkg::chs_cv_t         c_in;
        logic [chs_pkg::SQ_W-1:0] n_in;

        if (s == 0)
        begin : g_first
            assign v_in = in_vld;
            assign c_in = vec_in;
            assign n_in = ny_in;
        end
        else
        begin : g_next
            assign v_in = valid_reg[s-1];
            assign c_in = vec_reg[s-1];
            assign n_in = ny_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vec_reg[s] <= chs_pkg::cordic_step(c_in, s);
                ny_reg[s]  <= n_in;
            end
        end
    end

    assign out_vld = valid_reg[chs_pkg::CORDIC_STEPS-1];
    assign vec_out = vec_reg[chs_pkg::CORDIC_STEPS-1];
    assign ny_out  = ny_reg[chs_pkg::CORDIC_STEPS-1];

endmodule

// ===== rtl/core/chs_checker.sv =====
module chs_checker
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [15:0]       dir_x,
    input logic [14:0]              dir_y,
    input logic signed [15:0]       dir_z
);

    // The input side is held back only while a result waits to be taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // With no result held, a request is always taken.
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !out_valid) |-> !in_stall)
        else $error("input stalled while output is empty");

    // A held result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("held result withdrawn");

    // A held result keeps its value.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(dir_x) && $stable(dir_y) && $stable(dir_z)))
        else $error("held result changed");

endmodule

bind cosine_hemisphere_sampler_top chs_checker u_chs_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Direction expected for one request.
    typedef struct packed {
        logic signed [15:0] x;
        logic [14:0]        y;
        logic signed [15:0] z;
    } dir_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [chs_pkg::IN_W-1:0] u_radius;
    logic [chs_pkg::IN_W-1:0] u_angle;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [15:0]       dir_x;
    logic [14:0]              dir_y;
    logic signed [15:0]       dir_z;

    dir_t   expected_dirs[$];
    int     mismatch_count;
    int     dirs_checked;
    bit     hold_off_req;
    bit     random_stall;

    cosine_hemisphere_sampler_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .u_radius  (u_radius),
        .u_angle   (u_angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Arithmetic right shift rounding towards minus infinity.
    function automatic longint floor_shr(input longint v, input int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    // Integer square root by the digit-by-digit method.
    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint to_q15(input longint v, input longint lo, input longint hi);
        longint t;
        t = floor_shr(v + 16384, 15);
        if (t < lo)
            t = lo;
        if (t > hi)
            t = hi;
        return t;
    endfunction

    // Works out the sampled direction for one pair of uniform numbers.
    function automatic dir_t sample_direction(input logic [15:0] ur, input logic [15:0] ua);
        longint unsigned   u32;
        longint            root;
        longint            normal;
        longint            cx;
        longint            cy;
        longint            cz;
        longint            dx;
        longint            dy;
        logic [31:0]       phase;
        dir_t              d;
        longint            turns[24];
        turns = '{536870912, 316933406, 167458907, 84999124, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772,
                  166886, 83443, 41722, 20861, 10430, 5215,
                  2608, 1304, 652, 326, 163, 81};
        u32 = longint'(ur) << (32 - chs_pkg::FRAC_BITS);
        if (u32 > 64'h1_0000_0000)
            u32 = 64'h1_0000_0000;
        root = int_sqrt(u32 << 28);
        normal = int_sqrt((64'h1_0000_0000 - u32) << 28);
        phase = 32'(longint'(ua) << (32 - chs_pkg::FRAC_BITS));
        cx = (root * 652032874) >>> 30;
        cy = 0;
        // Second and third quarter turns start from the negated vector.
        if (phase[31:30] == 2'd1 || phase[31:30] == 2'd2)
        begin
            phase = phase + 32'h8000_0000;
            cx = -cx;
        end
        cz = longint'(signed'(phase));
        for (int i = 0; i < 24; i++)
        begin
            dx = floor_shr(cy, i);
            dy = floor_shr(cx, i);
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= turns[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += turns[i];
            end
        end
        d.x = 16'(to_q15(cx, -32768, 32767));
        d.y = 15'(to_q15(normal, 0, 32767));
        d.z = 16'(to_q15(cy, -32768, 32767));
        return d;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        mismatch_count++;
    endtask

    // Sends one request after the given gap and records its expected direction.
    // Valid stays high after acceptance so that a request with no gap follows directly.
    task automatic send_request(input logic [15:0] ur, input logic [15:0] ua, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        u_radius <= ur;
        u_angle  <= ua;
        expected_dirs.push_back(sample_direction(ur, ua));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_dirs.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall: random per result, or one long hold-off on request.
    initial
    begin
        int wait_left;
        out_stall = 1'b0;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (random_stall)
            begin
                if (wait_left > 0)
                begin
                    wait_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    if (out_valid && !out_stall)
                        wait_left = $urandom_range(0, 10);
                end
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        dir_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dirs.size() == 0)
            begin
                $display("unexpected direction at %0t", $time);
                mismatch_count++;
            end
            else
            begin
                want = expected_dirs.pop_front();
                dirs_checked++;
                if (dir_x !== want.x)
                    report_mismatch("dir_x", dir_x, want.x);
                if (dir_y !== want.y)
                    report_mismatch("dir_y", dir_y, want.y);
                if (dir_z !== want.z)
                    report_mismatch("dir_z", dir_z, want.z);
            end
        end
    end

    // Extremes, quadrant edges and full-scale components.
    task automatic test_directed();
        logic [15:0] radii[6];
        logic [15:0] angles[4];
        radii = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF, 16'h5555};
        angles = '{16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
        foreach (radii[i])
            foreach (angles[j])
                send_request(radii[i], angles[j], 0);
        send_request(16'hAAAA, 16'h7FFF, 0);
        wait_drained();
    endtask

    // Random pairs with random gaps on both sides.
    task automatic test_random(input int count);
        random_stall = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_request(16'($urandom), 16'($urandom), 0);
            else
                send_request(16'($urandom), 16'($urandom), $urandom_range(0, 10));
            // Occasionally run back-to-back stretches with no gaps at all.
            if (n % 400 == 200)
                for (int k = 0; k < 60; k++)
                    send_request(16'($urandom), 16'($urandom), 0);
        end
        wait_drained();
        random_stall = 1'b0;
    endtask

    // Long receiver hold-off while requests keep coming, so the pipeline fills.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int n = 0; n < 120; n++)
            send_request(16'($urandom), 16'($urandom), 0);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        u_radius = '0;
        u_angle = '0;
        mismatch_count = 0;
        dirs_checked = 0;
        hold_off_req = 1'b0;
        random_stall = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1800);
        repeat (80) @(posedge clk);
        $display("Checked %0d directions: corner radii and angles, random pairs,", dirs_checked);
        $display("random idling on both sides and a long output hold-off.");
        if (mismatch_count == 0 && expected_dirs.size() == 0)
            $display("** cosine_hemisphere_sampler_top: PASSED **");
        else
            $display("** cosine_hemisphere_sampler_top: FAILED **");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("timeout at %0t", $time);
        $display("** cosine_hemisphere_sampler_top: FAILED **");
        $finish;
    end

endmodule
